### sv/bht_pkg.sv
// shared types and constants for the bucketed hash table
`default_nettype none

package bht_pkg;

    localparam int DEF_BUCKETS = 8;
    localparam int DEF_WAYS    = 4;

    localparam int ACT_W   = 2;
    localparam int KEY_W   = 16;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DUP  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd3;

    typedef struct packed {
        logic               vld;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } slot_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH_MUL,
        S_HASH_REM,
        S_HASH_FIX,
        S_SCAN,
        S_APPLY
    } state_t;

endpackage

`default_nettype wire

### sv/bucketed_hash_table_top.sv
// bucketed hash table: key/value store with insert, delete and search
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------
//  in      | in_valid/in_ready  | action, key, value
//  out     | out_valid/out_ready| status, found_value
//
// a request is taken in the idle state and its result is registered in the update
// state: the key is reduced modulo BUCKETS with a reciprocal multiply in the
// multiply, remainder and fix-up states, each way is read and compared through the
// registered read port of the slot memory, then the update state writes the store;
// a new request is not taken until the previous one has left the update state.
// after reset all BUCKETS * 2**max(1, ceil(log2(WAYS))) entries of the slot memory
// are cleared before in_ready rises.
// a stalled result holds the update cycle; a new request may be taken while
// a result waits.
`default_nettype none

module bucketed_hash_table_top
    import bht_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int WAYS    = DEF_WAYS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [ACT_W-1:0]   action,
    input  wire logic [KEY_W-1:0]   key,
    input  wire logic [VALUE_W-1:0] value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [STAT_W-1:0]       status,
    output logic [VALUE_W-1:0]      found_value
);

    localparam int BW    = $clog2(BUCKETS);
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WCW   = $clog2(WAYS + 1);
    localparam int AW    = BW + WW;
    localparam int DEPTH = BUCKETS * (2 ** WW);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(BUCKETS));

    state_t state_reg;
    state_t state_next;

    slot_t mem [DEPTH];
    slot_t rd_data_reg;
    logic [AW-1:0] rd_addr;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    slot_t         mem_wdata;

    logic [AW-1:0] clr_cnt_reg;

    logic [ACT_W-1:0]   action_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;

    logic [47:0]   prod_reg;
    logic [15:0]   quot;
    logic [24:0]   rem_full;
    logic [BW:0]   rem_reg;
    logic [BW-1:0] bucket_reg;

    logic [WCW-1:0] issue_way_reg;
    logic           issue_en;
    logic           cmp_vld_reg;
    logic [WW-1:0]  cmp_way_reg;

    logic               hit_reg;
    logic [WW-1:0]      hit_way_reg;
    logic [VALUE_W-1:0] hit_value_reg;
    logic               free_reg;
    logic [WW-1:0]      free_way_reg;

    logic               apply_go;
    logic [STAT_W-1:0]  res_status;
    logic [VALUE_W-1:0] res_value;

    logic               out_valid_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [VALUE_W-1:0] found_value_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_HASH_MUL;
                end
            end
            S_HASH_MUL: state_next = S_HASH_REM;
            S_HASH_REM: state_next = S_HASH_FIX;
            S_HASH_FIX: state_next = S_SCAN;
            S_SCAN:
            begin
                if (issue_way_reg == WCW'(WAYS) && !cmp_vld_reg)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (apply_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready   = 1'b0;
        issue_en   = 1'b0;
        apply_go   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = clr_cnt_reg;
        mem_wdata  = '0;
        res_status = STAT_MISS;
        res_value  = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_SCAN:
            begin
                issue_en = (issue_way_reg < WCW'(WAYS));
            end
            S_APPLY:
            begin
                apply_go = !out_valid_reg || out_ready;
                case (action_reg)
                    ACT_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            res_status = STAT_DUP;
                        end
                        else if (free_reg)
                        begin
                            res_status      = STAT_OK;
                            mem_we          = apply_go;
                            mem_waddr       = {bucket_reg, free_way_reg};
                            mem_wdata.vld   = 1'b1;
                            mem_wdata.key   = key_reg;
                            mem_wdata.value = value_reg;
                        end
                        else
                        begin
                            res_status = STAT_FULL;
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (hit_reg)
                        begin
                            res_status = STAT_OK;
                            mem_we     = apply_go;
                            mem_waddr  = {bucket_reg, hit_way_reg};
                        end
                    end
                    ACT_SEARCH:
                    begin
                        if (hit_reg)
                        begin
                            res_status = STAT_OK;
                            res_value  = hit_value_reg;
                        end
                    end
                    default:
                    begin
                        res_status = STAT_MISS;
                    end
                endcase
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (state_reg == S_CLEAR)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // slot memory
    assign rd_addr = {bucket_reg, issue_way_reg[WW-1:0]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // request capture and key reduction modulo BUCKETS
    assign quot     = prod_reg[47:32];
    assign rem_full = 25'(key_reg) - 25'(quot) * 25'(BUCKETS);

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg <= action;
            key_reg    <= key;
            value_reg  <= value;
        end
        if (state_reg == S_HASH_MUL)
        begin
            prod_reg <= 48'(key_reg) * 48'(RECIP);
        end
        if (state_reg == S_HASH_REM)
        begin
            rem_reg <= rem_full[BW:0];
        end
        if (state_reg == S_HASH_FIX)
        begin
            bucket_reg <= (rem_reg >= (BW + 1)'(BUCKETS))
                          ? BW'(rem_reg - (BW + 1)'(BUCKETS)) : rem_reg[BW-1:0];
        end
    end

    // bucket scan, one way per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_way_reg <= '0;
            cmp_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= issue_en;
            if (state_reg == S_HASH_FIX)
            begin
                issue_way_reg <= '0;
                hit_reg       <= 1'b0;
                free_reg      <= 1'b0;
            end
            else
            begin
                if (issue_en)
                begin
                    issue_way_reg <= issue_way_reg + 1'b1;
                end
                if (cmp_vld_reg)
                begin
                    if (rd_data_reg.vld && rd_data_reg.key == key_reg && !hit_reg)
                    begin
                        hit_reg <= 1'b1;
                    end
                    if (!rd_data_reg.vld && !free_reg)
                    begin
                        free_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_en)
        begin
            cmp_way_reg <= issue_way_reg[WW-1:0];
        end
        if (cmp_vld_reg && rd_data_reg.vld && rd_data_reg.key == key_reg && !hit_reg)
        begin
            hit_way_reg   <= cmp_way_reg;
            hit_value_reg <= rd_data_reg.value;
        end
        if (cmp_vld_reg && !rd_data_reg.vld && !free_reg)
        begin
            free_way_reg <= cmp_way_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_APPLY && apply_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_APPLY && apply_go)
        begin
            status_reg      <= res_status;
            found_value_reg <= res_value;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_value = found_value_reg;

    a_result_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_APPLY))
        else $error("result appeared outside the update cycle");

    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_APPLY))
        else $error("slot memory written during lookup");

    a_insert_no_dup: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == S_APPLY && mem_wdata.vld) |-> (!hit_reg && free_reg))
        else $error("insert wrote a duplicate key or into a full bucket");

    a_value_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_value_reg != '0) |-> (status_reg == STAT_OK))
        else $error("found_value set without a hit");

endmodule

`default_nettype wire

### dv/bucketed_hash_table_top_tb.sv
// testbench for the bucketed hash table: directed and random requests checked against a predictor
`default_nettype none

module bucketed_hash_table_top_tb;
    import bht_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUCKETS     = DEF_BUCKETS;
    localparam int WAYS        = DEF_WAYS;
    localparam int NUM_SLOTS   = BUCKETS * WAYS;
    localparam int POOL_SIZE   = 48;
    localparam int IDLE_PCT    = 23;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [VALUE_W-1:0] found_value;
    } result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [ACT_W-1:0]   action;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic               out_valid;
    logic               out_ready;
    logic [STAT_W-1:0]  status;
    logic [VALUE_W-1:0] found_value;

    slot_t            shadow_slots [NUM_SLOTS];
    result_t          pending_results [$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    int  fail_cnt;
    int  cycle_cnt;
    int  req_cnt;
    int  status_seen [4];
    bit  steady_flow;
    int  hold_req;
    int  hold_ack;
    int  hold_left;

    bucketed_hash_table_top #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found_value (found_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                     pending_results.size());
            $display("FAIL bucketed_hash_table_top");
            $finish;
        end
    end

    // applies one request to the shadow store and returns the result it should give
    function automatic result_t apply_request(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k,
                                              logic [VALUE_W-1:0] v);
        result_t res;
        int      base;
        int      hit;
        int      s;
        res.status      = STAT_MISS;
        res.found_value = '0;
        base = (int'(k) % BUCKETS) * WAYS;
        hit  = -1;
        for (int w = 0; w < WAYS; w++)
        begin
            s = base + w;
            if (hit < 0 && shadow_slots[s].vld && shadow_slots[s].key == k)
                hit = s;
        end
        case (act)
            ACT_INSERT:
            begin
                if (hit >= 0)
                    res.status = STAT_DUP;
                else
                begin
                    res.status = STAT_FULL;
                    for (int w = 0; w < WAYS; w++)
                    begin
                        s = base + w;
                        if (res.status == STAT_FULL && !shadow_slots[s].vld)
                        begin
                            shadow_slots[s].vld   = 1'b1;
                            shadow_slots[s].key   = k;
                            shadow_slots[s].value = v;
                            res.status = STAT_OK;
                        end
                    end
                end
            end
            ACT_DELETE:
            begin
                if (hit >= 0)
                begin
                    shadow_slots[hit].vld = 1'b0;
                    res.status = STAT_OK;
                end
            end
            ACT_SEARCH:
            begin
                if (hit >= 0)
                begin
                    res.status      = STAT_OK;
                    res.found_value = shadow_slots[hit].value;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // called just after a falling edge; returns just after the falling edge after acceptance
    task automatic send_request(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k,
                                logic [VALUE_W-1:0] v);
        if (!steady_flow)
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        in_valid <= 1'b1;
        action   <= act;
        key      <= k;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(apply_request(act, k, v));
        req_cnt++;
        @(negedge clk);
    endtask

    task automatic send_random_batch(int n);
        int               sent;
        int               r;
        logic [ACT_W-1:0] act;
        logic [KEY_W-1:0] k;
        sent = 0;
        while (sent < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                act = ACT_INSERT;
            else if (r < 70)
                act = ACT_DELETE;
            else if (r < 95)
                act = ACT_SEARCH;
            else
                act = ACT_UNUSED;
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            // stray keys only probe, so the store holds pool keys alone
            if (act != ACT_INSERT && $urandom_range(0, 99) < 10)
                k = KEY_W'($urandom_range(0, 65535));
            send_request(act, k, $urandom);
            sent++;
        end
    endtask

    task automatic test_empty_table();
        send_request(ACT_SEARCH, 16'h0000, 32'hFFFF_FFFF);
        send_request(ACT_DELETE, 16'hFFFF, 32'h0000_0000);
        send_request(ACT_UNUSED, 16'h0005, 32'hA5A5_5A5A);
    endtask

    task automatic test_insert_search();
        send_request(ACT_INSERT, 16'h0000, 32'h0000_0000);
        send_request(ACT_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(ACT_SEARCH, 16'h0000, 32'h1234_5678);
        send_request(ACT_SEARCH, 16'hFFFF, 32'h0000_0000);
        send_request(ACT_INSERT, 16'h0000, 32'hDEAD_BEEF);
        send_request(ACT_DELETE, 16'h0000, 32'h0000_0000);
        send_request(ACT_SEARCH, 16'h0000, 32'h0000_0000);
    endtask

    task automatic test_bucket_full();
        send_request(ACT_INSERT, 16'd3, 32'h0000_0003);
        send_request(ACT_INSERT, 16'd11, 32'h0000_000B);
        send_request(ACT_INSERT, 16'd19, 32'h0000_0013);
        send_request(ACT_INSERT, 16'd65531, 32'h8000_0001);
        send_request(ACT_INSERT, 16'd27, 32'h0000_001B);
        send_request(ACT_DELETE, 16'd19, 32'h0000_0000);
        send_request(ACT_INSERT, 16'd35, 32'h7FFF_FFFF);
        send_request(ACT_SEARCH, 16'd35, 32'h0000_0000);
        send_request(ACT_SEARCH, 16'd65531, 32'h0000_0000);
        send_request(ACT_DELETE, 16'd19, 32'h0000_0000);
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = KEY_W'($urandom_range(0, 65535));
        send_random_batch(650);
    endtask

    task automatic test_steady_flow();
        steady_flow = 1'b1;
        send_random_batch(120);
        steady_flow = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_req++;
        send_random_batch(80);
    endtask

    // result sink: random stalls plus one long hold-off when requested
    initial
    begin
        out_ready = 1'b0;
        hold_ack  = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_ack)
            begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding: status %0d found_value 0x%08h",
                       status, found_value);
                fail_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                status_seen[status]++;
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    fail_cnt++;
                end
                if (found_value !== want.found_value)
                begin
                    $error("found_value: expected 0x%08h, actual 0x%08h",
                           want.found_value, found_value);
                    fail_cnt++;
                end
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        action      = ACT_INSERT;
        key         = '0;
        value       = '0;
        fail_cnt    = 0;
        cycle_cnt   = 0;
        req_cnt     = 0;
        steady_flow = 1'b0;
        hold_req    = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
            shadow_slots[i] = '0;
        for (int i = 0; i < 4; i++)
            status_seen[i] = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_insert_search();
        test_bucket_full();
        test_random_traffic();
        test_steady_flow();
        test_backpressure();

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4 * (WAYS + 6)) @(negedge clk);

        $display("%0d requests over %0d cycles, including a %0d-cycle result stall",
                 req_cnt, cycle_cnt, HOLD_CYCLES);
        $display("results seen: ok %0d, duplicate %0d, not found %0d, bucket full %0d",
                 status_seen[STAT_OK], status_seen[STAT_DUP], status_seen[STAT_MISS],
                 status_seen[STAT_FULL]);
        if (fail_cnt == 0)
            $display("PASS bucketed_hash_table_top");
        else
            $display("FAIL bucketed_hash_table_top");
        $finish;
    end

endmodule

`default_nettype wire
